// ===== rtl/spmm_pkg.sv =====
package spmm_pkg;

    localparam int ROWS_A_DEF    = 8;
    localparam int INNER_DIM_DEF = 8;
    localparam int COLS_B_DEF    = 8;
    localparam int DATA_W_DEF    = 16;

    localparam int CMD_W   = 3;
    localparam int ADDR_W  = 6;
    localparam int VALUE_W = 16;
    localparam int INDEX_W = 7;
    localparam int POS_W   = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_A   = 3'd0,
        CMD_LOAD_AP  = 3'd1,
        CMD_LOAD_B   = 3'd2,
        CMD_LOAD_BP  = 3'd3,
        CMD_START    = 3'd4,
        CMD_NOP5     = 3'd5,
        CMD_NOP6     = 3'd6,
        CMD_NOP7     = 3'd7
    } cmd_t;

    // classified operation passed from front to back
    typedef struct packed {
        cmd_t               cmd;
        logic [ADDR_W-1:0]  addr;
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
    } op_t;

endpackage

// ===== rtl/spmm_if.sv =====
interface spmm_if #(
    parameter int PAYLOAD_W = 1
);
    logic                 valid;
    logic                 ready;
    logic [PAYLOAD_W-1:0] payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/spmm_front.sv =====
module spmm_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  spmm_pkg::op_t  in_op,
    output logic           q_valid,
    input  logic           q_ready,
    output spmm_pkg::op_t  q_op
);

    localparam int DEPTH = 2;

    spmm_pkg::op_t fifo_reg [DEPTH];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          push, pop;
    logic          keep;

    // drop codes that carry no work
    assign keep = (in_op.cmd == spmm_pkg::CMD_LOAD_A) || (in_op.cmd == spmm_pkg::CMD_LOAD_AP)
               || (in_op.cmd == spmm_pkg::CMD_LOAD_B) || (in_op.cmd == spmm_pkg::CMD_LOAD_BP)
               || (in_op.cmd == spmm_pkg::CMD_START);

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready && keep;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_op     = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= in_op;
        end
    end

endmodule

// ===== rtl/spmm_back.sv =====
module spmm_back #(
    parameter int ROWS_A    = spmm_pkg::ROWS_A_DEF,
    parameter int INNER_DIM = spmm_pkg::INNER_DIM_DEF,
    parameter int COLS_B    = spmm_pkg::COLS_B_DEF,
    parameter int DATA_W    = spmm_pkg::DATA_W_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  spmm_pkg::op_t               q_op,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [spmm_pkg::VALUE_W-1:0] c_value,
    output logic [spmm_pkg::POS_W-1:0]  row,
    output logic [spmm_pkg::POS_W-1:0]  col,
    output logic                        last
);

    localparam int A_LEN = ROWS_A * INNER_DIM;
    localparam int B_LEN = INNER_DIM * COLS_B;
    localparam int C_LEN = ROWS_A * COLS_B;
    localparam int PW    = spmm_pkg::INDEX_W;
    localparam int AW    = (A_LEN > 1) ? $clog2(A_LEN) : 1;
    localparam int BW    = (B_LEN > 1) ? $clog2(B_LEN) : 1;
    localparam int CW    = (C_LEN > 1) ? $clog2(C_LEN) : 1;
    localparam int RW    = (ROWS_A > 1) ? $clog2(ROWS_A) : 1;
    localparam int KW    = (INNER_DIM > 1) ? $clog2(INNER_DIM) : 1;
    localparam int JW    = (COLS_B > 1) ? $clog2(COLS_B) : 1;
    localparam int VW    = spmm_pkg::VALUE_W;
    localparam int XW    = (DATA_W < VW) ? VW : DATA_W;
    localparam logic [PW-1:0] A_LEN_P = PW'(A_LEN);
    localparam logic [PW-1:0] B_LEN_P = PW'(B_LEN);

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLR, ST_ROW, ST_AENT, ST_AWAIT, ST_BPTR, ST_BENT, ST_BWAIT,
        ST_ACC_WAIT, ST_MAC, ST_EMIT_RD, ST_EMIT, ST_DRAIN
    } state_t;

    // stores
    logic [DATA_W-1:0] a_vals [A_LEN];
    logic [PW-1:0]     a_colidx [A_LEN];
    logic [PW-1:0]     a_rowstart [ROWS_A+1];
    logic [DATA_W-1:0] b_vals [B_LEN];
    logic [PW-1:0]     b_rowidx [B_LEN];
    logic [PW-1:0]     b_colstart [INNER_DIM+1];
    logic [DATA_W-1:0] acc_mem [C_LEN];

    state_t            state_reg;
    logic [RW:0]       i_reg;
    logic [PW-1:0]     ia_reg, ae_reg, ib_reg, be_reg;
    logic [KW-1:0]     k_reg;
    logic [DATA_W-1:0] av_reg, bv_reg, prod_reg, acc_rd_reg;
    logic [CW:0]       c_reg;
    logic [spmm_pkg::POS_W-1:0] erow_reg, ecol_reg;
    logic [PW-1:0]     ard_col_reg, brd_row_reg;
    logic [DATA_W-1:0] ard_val_reg, brd_val_reg;
    logic [VW-1:0]     out_val_reg;
    logic [spmm_pkg::POS_W-1:0] out_row_reg, out_col_reg;
    logic              out_valid_reg, out_last_reg;
    logic [DATA_W-1:0] in_wide;
    logic [XW-1:0]     sx;

    function automatic logic [PW-1:0] clampa(input logic [PW-1:0] p);
        return (p > A_LEN_P) ? A_LEN_P : p;
    endfunction
    function automatic logic [PW-1:0] clampb(input logic [PW-1:0] p);
        return (p > B_LEN_P) ? B_LEN_P : p;
    endfunction

    assign sx      = XW'(signed'(q_op.value));
    assign in_wide = sx[DATA_W-1:0];
    assign q_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign c_value = out_val_reg;
    assign row     = out_row_reg;
    assign col     = out_col_reg;
    assign last    = out_last_reg;

    // load writes
    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready)
        begin
            unique case (q_op.cmd)
                spmm_pkg::CMD_LOAD_A:
                begin
                    if (32'(q_op.addr) < A_LEN)
                    begin
                        a_vals[q_op.addr[AW-1:0]]   <= in_wide;
                        a_colidx[q_op.addr[AW-1:0]] <= q_op.index;
                    end
                end
                spmm_pkg::CMD_LOAD_AP:
                begin
                    if (32'(q_op.addr) <= ROWS_A)
                    begin
                        a_rowstart[q_op.addr[RW:0]] <= q_op.index;
                    end
                end
                spmm_pkg::CMD_LOAD_B:
                begin
                    if (32'(q_op.addr) < B_LEN)
                    begin
                        b_vals[q_op.addr[BW-1:0]]   <= in_wide;
                        b_rowidx[q_op.addr[BW-1:0]] <= q_op.index;
                    end
                end
                spmm_pkg::CMD_LOAD_BP:
                begin
                    if (32'(q_op.addr) <= INNER_DIM)
                    begin
                        b_colstart[q_op.addr[KW:0]] <= q_op.index;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // entry reads, registered
    always_ff @(posedge clk)
    begin
        ard_val_reg <= a_vals[ia_reg[AW-1:0]];
        ard_col_reg <= a_colidx[ia_reg[AW-1:0]];
        brd_val_reg <= b_vals[ib_reg[BW-1:0]];
        brd_row_reg <= b_rowidx[ib_reg[BW-1:0]];
        acc_rd_reg  <= acc_mem[c_reg[CW-1:0]];
    end

    // accumulator writes
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLR)
        begin
            acc_mem[c_reg[CW-1:0]] <= '0;
        end
        else if (state_reg == ST_MAC)
        begin
            acc_mem[c_reg[CW-1:0]] <= acc_rd_reg + prod_reg;
        end
    end

    // control sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            c_reg         <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid && q_op.cmd == spmm_pkg::CMD_START)
                    begin
                        c_reg     <= '0;
                        state_reg <= ST_CLR;
                    end
                end
                ST_CLR:
                begin
                    if (32'(c_reg) == C_LEN - 1)
                    begin
                        i_reg     <= '0;
                        state_reg <= ST_ROW;
                    end
                    else
                    begin
                        c_reg <= c_reg + 1'b1;
                    end
                end
                ST_ROW:
                begin
                    if (32'(i_reg) == ROWS_A)
                    begin
                        c_reg     <= '0;
                        erow_reg  <= '0;
                        ecol_reg  <= '0;
                        state_reg <= ST_EMIT_RD;
                    end
                    else
                    begin
                        ia_reg    <= clampa(a_rowstart[i_reg]);
                        ae_reg    <= clampa(a_rowstart[i_reg + 1'b1]);
                        state_reg <= ST_AENT;
                    end
                end
                ST_AENT:
                begin
                    if (ia_reg >= ae_reg)
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_ROW;
                    end
                    else
                    begin
                        state_reg <= ST_AWAIT;
                    end
                end
                ST_AWAIT:
                begin
                    if (32'(ard_col_reg) >= INNER_DIM)
                    begin
                        ia_reg    <= ia_reg + 1'b1;
                        state_reg <= ST_AENT;
                    end
                    else
                    begin
                        k_reg     <= ard_col_reg[KW-1:0];
                        av_reg    <= ard_val_reg;
                        state_reg <= ST_BPTR;
                    end
                end
                ST_BPTR:
                begin
                    ib_reg    <= clampb(b_colstart[k_reg]);
                    be_reg    <= clampb(b_colstart[{1'b0, k_reg} + 1'b1]);
                    state_reg <= ST_BENT;
                end
                ST_BENT:
                begin
                    if (ib_reg >= be_reg)
                    begin
                        ia_reg    <= ia_reg + 1'b1;
                        state_reg <= ST_AENT;
                    end
                    else
                    begin
                        state_reg <= ST_BWAIT;
                    end
                end
                ST_BWAIT:
                begin
                    // b entry read has landed
                    if (32'(brd_row_reg) >= COLS_B)
                    begin
                        ib_reg    <= ib_reg + 1'b1;
                        state_reg <= ST_BENT;
                    end
                    else
                    begin
                        bv_reg    <= brd_val_reg;
                        c_reg     <= (CW+1)'(32'(i_reg) * COLS_B + 32'(brd_row_reg));
                        state_reg <= ST_ACC_WAIT;
                    end
                end
                ST_MAC:
                begin
                    ib_reg    <= ib_reg + 1'b1;
                    state_reg <= ST_BENT;
                end
                ST_EMIT_RD:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_val_reg   <= VW'(acc_rd_reg);
                        out_row_reg   <= erow_reg;
                        out_col_reg   <= ecol_reg;
                        out_last_reg  <= (32'(c_reg) == C_LEN - 1);
                        if (32'(c_reg) == C_LEN - 1)
                        begin
                            state_reg <= ST_DRAIN;
                        end
                        else
                        begin
                            c_reg     <= c_reg + 1'b1;
                            if (32'(ecol_reg) == COLS_B - 1)
                            begin
                                ecol_reg <= '0;
                                erow_reg <= erow_reg + 1'b1;
                            end
                            else
                            begin
                                ecol_reg <= ecol_reg + 1'b1;
                            end
                            state_reg <= ST_EMIT_RD;
                        end
                    end
                end
                ST_DRAIN:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                ST_ACC_WAIT:
                begin
                    prod_reg  <= av_reg * bv_reg;
                    state_reg <= ST_MAC;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (state_reg != ST_EMIT && state_reg != ST_DRAIN && out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/sparse_csr_csc_matrix_multiply.sv =====
// Sparse matrix multiply, A in compressed rows times B in compressed columns.
// Load transactions (cmd 0..3) write one entry or pointer and are taken one
// per cycle through a two-entry queue. A start transaction clears the
// ROWS_A*COLS_B accumulator (one entry a cycle), then walks each row's A
// nonzeros and the matching B segment, skipping an A nonzero whose column is
// out of range and forming each product in the single multiply-accumulate
// unit, then emits all C elements in row-major order with the final one
// marked last. While a start runs, the queue takes at most two more load or
// start transactions (codes 5..7 are taken and dropped) and input is then
// held off until the final element has been taken. Values wrap to DATA_W
// bits.
module sparse_csr_csc_matrix_multiply #(
    parameter int ROWS_A    = spmm_pkg::ROWS_A_DEF,
    parameter int INNER_DIM = spmm_pkg::INNER_DIM_DEF,
    parameter int COLS_B    = spmm_pkg::COLS_B_DEF,
    parameter int DATA_W    = spmm_pkg::DATA_W_DEF
) (
    input logic clk,
    input logic rst_n,
    spmm_if.sink   in_ch,
    spmm_if.source out_ch
);

    spmm_pkg::op_t in_op, q_op;
    logic          q_valid, q_ready;
    logic [spmm_pkg::VALUE_W-1:0] c_value;
    logic [spmm_pkg::POS_W-1:0]   row, col;
    logic          last;

    assign in_op = in_ch.payload;

    spmm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .in_op    (in_op),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_op     (q_op)
    );

    spmm_back #(
        .ROWS_A    (ROWS_A),
        .INNER_DIM (INNER_DIM),
        .COLS_B    (COLS_B),
        .DATA_W    (DATA_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_op      (q_op),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .c_value   (c_value),
        .row       (row),
        .col       (col),
        .last      (last)
    );

    // output payload: c_value, row, col, last
    assign out_ch.payload = {c_value, row, col, last};

endmodule

// ===== sim/sparse_csr_csc_matrix_multiply_tb.sv =====
module sparse_csr_csc_matrix_multiply_tb;

    localparam int ELEMS      = 64;
    localparam int PTRS       = 9;
    localparam int ITEM_GOAL  = 480;
    localparam int CYCLE_CAP  = 50000000;
    localparam int DRAIN_WAIT = 200;

    // one emitted product element
    typedef struct packed {
        logic [15:0] c_value;
        logic [2:0]  row;
        logic [2:0]  col;
        logic        last;
    } elem_t;

    logic clk;
    logic rst_n;

    spmm_if #(.PAYLOAD_W($bits(spmm_pkg::op_t))) in_ch ();
    spmm_if #(.PAYLOAD_W($bits(elem_t)))         out_ch ();

    sparse_csr_csc_matrix_multiply u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // shadow copy of the block's stores
    logic [15:0] a_val_mem [ELEMS];
    logic [6:0]  a_col_mem [ELEMS];
    logic [6:0]  a_ptr_mem [PTRS];
    logic [15:0] b_val_mem [ELEMS];
    logic [6:0]  b_col_mem [ELEMS];
    logic [6:0]  b_ptr_mem [PTRS];
    logic [15:0] c_acc [ELEMS];

    spmm_pkg::op_t op_queue [$];
    elem_t         c_expected [$];
    int            errors       = 0;
    int            accepted_ops = 0;
    int            start_count  = 0;
    int            elem_count   = 0;
    int            cycles       = 0;
    bit            calm         = 1'b0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // idle length: mostly short, a few long, none during calm stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int clamp64(logic [6:0] p);
        return (p > ELEMS) ? ELEMS : int'(p);
    endfunction

    // update the shadow stores and queue the product elements of a start
    task automatic apply_op(spmm_pkg::op_t op);
        int ae;
        int be;
        int k;
        int j;
        logic [15:0] prod;
        elem_t e;
        case (op.cmd)
            spmm_pkg::CMD_LOAD_A:
            begin
                a_val_mem[op.addr] = op.value;
                a_col_mem[op.addr] = op.index;
            end
            spmm_pkg::CMD_LOAD_AP:
            begin
                if (op.addr < PTRS) a_ptr_mem[op.addr] = op.index;
            end
            spmm_pkg::CMD_LOAD_B:
            begin
                b_val_mem[op.addr] = op.value;
                b_col_mem[op.addr] = op.index;
            end
            spmm_pkg::CMD_LOAD_BP:
            begin
                if (op.addr < PTRS) b_ptr_mem[op.addr] = op.index;
            end
            spmm_pkg::CMD_START:
            begin
                start_count++;
                for (int c = 0; c < ELEMS; c++) c_acc[c] = '0;
                for (int i = 0; i < 8; i++)
                begin
                    ae = clamp64(a_ptr_mem[i+1]);
                    for (int ia = clamp64(a_ptr_mem[i]); ia < ae; ia++)
                    begin
                        k = a_col_mem[ia];
                        if (k < 8)
                        begin
                            be = clamp64(b_ptr_mem[k+1]);
                            for (int ib = clamp64(b_ptr_mem[k]); ib < be; ib++)
                            begin
                                j = b_col_mem[ib];
                                if (j < 8)
                                begin
                                    prod = a_val_mem[ia] * b_val_mem[ib];
                                    c_acc[i*8+j] = c_acc[i*8+j] + prod;
                                end
                            end
                        end
                    end
                end
                for (int c = 0; c < ELEMS; c++)
                begin
                    e.c_value = c_acc[c];
                    e.row     = 3'(c / 8);
                    e.col     = 3'(c % 8);
                    e.last    = (c == ELEMS - 1);
                    c_expected.push_back(e);
                end
            end
            default: ;
        endcase
    endtask

    task automatic push_op(spmm_pkg::cmd_t cmd, int addr, int value, int index);
        spmm_pkg::op_t op;
        op.cmd   = cmd;
        op.addr  = 6'(addr);
        op.value = 16'(value);
        op.index = 7'(index);
        op_queue.push_back(op);
    endtask

    function automatic int rand_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return -32768;
        if (r == 1) return 32767;
        if (r == 2) return $urandom_range(0, 6) - 3;
        return $urandom_range(0, 65535);
    endfunction

    // inner or output index: mostly in range, sometimes out of range
    function automatic int rand_index();
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 127);
        return $urandom_range(0, 7);
    endfunction

    // pointer array as a mostly ascending walk, sometimes arbitrary
    task automatic push_ptrs(spmm_pkg::cmd_t cmd);
        int p;
        int step;
        bit wild;
        p    = $urandom_range(0, 56);
        wild = ($urandom_range(0, 9) == 0);
        for (int a = 0; a < PTRS; a++)
        begin
            step = $urandom_range(0, 2);
            if (wild)
                p = $urandom_range(0, 64);
            else
                p = (p + step > 64) ? 64 : p + step;
            if ($urandom_range(0, 9) < 8 || a == 0)
                push_op(cmd, a, $urandom_range(0, 65535), p);
        end
    endtask

    // input driver fed from the pending queue
    spmm_pkg::op_t cur_op;
    int            in_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid   <= 1'b0;
            in_ch.payload <= '0;
            in_gap        <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                apply_op(cur_op);
                accepted_ops++;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap      <= in_gap - 1;
                    in_ch.valid <= 1'b0;
                end
                else if (op_queue.size() > 0)
                begin
                    cur_op         = op_queue.pop_front();
                    in_ch.payload <= cur_op;
                    in_ch.valid   <= 1'b1;
                    in_gap        <= pick_gap();
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // output monitor with random back-pressure
    int    out_gap;
    elem_t got;
    elem_t want;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            out_gap      <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = out_ch.payload;
                elem_count++;
                if (c_expected.size() == 0)
                begin
                    $display("%0t: unexpected element, actual %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = c_expected.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: element mismatch, expected val=%h row=%0d col=%0d last=%b,",
                                 $time, want.c_value, want.row, want.col, want.last,
                                 " actual val=%h row=%0d col=%0d last=%b",
                                 got.c_value, got.row, got.col, got.last);
                        errors++;
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap      <= out_gap - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                out_gap      <= pick_gap();
            end
        end
    end

    // watchdog and calm-stretch toggle
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if ($urandom_range(0, 199) == 0) calm <= ~calm;
        if (cycles > CYCLE_CAP)
        begin
            $display("%0t: timeout, %0d elements still expected", $time, c_expected.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int n;
        rst_n = 1'b0;

        // directed: all-empty matrices, ignored loads and unused codes
        for (int a = 0; a < PTRS; a++) push_op(spmm_pkg::CMD_LOAD_AP, a, 0, 0);
        for (int a = 0; a < PTRS; a++) push_op(spmm_pkg::CMD_LOAD_BP, a, 0, 0);
        push_op(spmm_pkg::CMD_LOAD_AP, 63, 0, 127);
        push_op(spmm_pkg::CMD_LOAD_BP, 9, 0, 64);
        push_op(spmm_pkg::CMD_NOP5, 21, 16'h5555, 42);
        push_op(spmm_pkg::CMD_NOP6, 42, 16'haaaa, 85);
        push_op(spmm_pkg::CMD_NOP7, 63, 16'hffff, 127);
        push_op(spmm_pkg::CMD_START, 0, 0, 0);

        // fill every entry once so any pointer is safe afterwards
        for (int a = 0; a < ELEMS; a++)
            push_op(spmm_pkg::CMD_LOAD_A, a,
                    (a == 0) ? -32768 : (a == 1) ? 32767 : rand_value(), rand_index());
        for (int a = 0; a < ELEMS; a++)
            push_op(spmm_pkg::CMD_LOAD_B, a,
                    (a == 0) ? -32768 : (a == 1) ? 32767 : rand_value(), rand_index());

        // random matrix sets, each ending in a start
        while (op_queue.size() < ITEM_GOAL)
        begin
            n = $urandom_range(0, 8);
            for (int e = 0; e < n; e++)
                push_op(spmm_pkg::CMD_LOAD_A, $urandom_range(0, 63), rand_value(),
                        rand_index());
            n = $urandom_range(0, 8);
            for (int e = 0; e < n; e++)
                push_op(spmm_pkg::CMD_LOAD_B, $urandom_range(0, 63), rand_value(),
                        rand_index());
            push_ptrs(spmm_pkg::CMD_LOAD_AP);
            push_ptrs(spmm_pkg::CMD_LOAD_BP);
            if ($urandom_range(0, 3) == 0)
                push_op(spmm_pkg::CMD_LOAD_AP, $urandom_range(9, 63), rand_value(),
                        $urandom_range(0, 127));
            if ($urandom_range(0, 3) == 0)
                push_op(spmm_pkg::cmd_t'(spmm_pkg::CMD_NOP5 + $urandom_range(0, 2)),
                        $urandom_range(0, 63), rand_value(), $urandom_range(0, 127));
            push_op(spmm_pkg::CMD_START, $urandom_range(0, 63), rand_value(),
                    $urandom_range(0, 127));
        end

        repeat (5) @(posedge clk);
        rst_n = 1'b1;

        // drain
        while (op_queue.size() > 0) @(posedge clk);
        @(posedge clk);
        while (in_ch.valid || c_expected.size() > 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d input transactions, %0d starts, %0d product elements checked",
                 accepted_ops, start_count, elem_count);
        if (errors == 0 && c_expected.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
